>>> src/ecal_pkg.sv
// Shared constants, types and helpers for the epoch-seconds to calendar converter.
// No dependencies; imported by every module of the block.
package ecal_pkg;

  // Last calendar year that converts; later inputs are flagged out of range
  localparam int unsigned MAX_YEAR = 9999;

  // Pipeline depth: stage 0 takes the input word, stage NSTG-1 is the output register
  localparam int unsigned NSTG = 13;

  localparam longint unsigned SECS_PER_MIN  = 60;
  localparam longint unsigned SECS_PER_HOUR = 60 * 60;
  localparam longint unsigned SECS_PER_DAY  = 60 * 60 * 24;

  // Days per 400-year era, and the day number of 1970-01-01 counted from 0000-03-01
  localparam longint unsigned DAYS_PER_ERA  = 146097;
  localparam longint unsigned DAYS_TO_EPOCH = 719468;

  // Leap years in 1..1969, then the day count at which MAX_YEAR has ended
  localparam longint unsigned LEAPS_1969 = 1969 / 4 - 1969 / 100 + 1969 / 400;
  localparam longint unsigned DAYS_LIMIT = 365 * (longint'(MAX_YEAR) + 1 - 1970)
                                           + longint'(MAX_YEAR) / 4
                                           - longint'(MAX_YEAR) / 100
                                           + longint'(MAX_YEAR) / 400 - LEAPS_1969;
  localparam logic [39:0] TS_LIMIT = 40'(DAYS_LIMIT * SECS_PER_DAY);

  // Seconds per day split as 2^7 * 675: the low 7 bits bypass the divider
  localparam int unsigned    DAY_LO_BITS = 7;
  localparam longint unsigned DAY_ODD    = SECS_PER_DAY >> DAY_LO_BITS;

  // Exact reciprocals: x / d == (x * ceil(2^k / d)) >> k for x below 2^(k - ceil(log2 d))
  localparam int unsigned SH_675   = 41;
  localparam int unsigned SH_ERA   = 40;
  localparam int unsigned SH_1460  = 29;
  localparam int unsigned SH_36524 = 34;
  localparam int unsigned SH_365   = 27;
  localparam int unsigned SH_100   = 16;
  localparam int unsigned SH_153   = 19;
  localparam int unsigned SH_60S   = 23;
  localparam int unsigned SH_60M   = 17;

  localparam logic [31:0] RCP_675   = 32'(((64'd1 << SH_675) + DAY_ODD - 1) / DAY_ODD);
  localparam logic [22:0] RCP_ERA   = 23'(((64'd1 << SH_ERA) + DAYS_PER_ERA - 1)
                                          / DAYS_PER_ERA);
  localparam logic [18:0] RCP_1460  = 19'(((64'd1 << SH_1460) + 1459) / 1460);
  localparam logic [18:0] RCP_36524 = 19'(((64'd1 << SH_36524) + 36523) / 36524);
  localparam logic [18:0] RCP_365   = 19'(((64'd1 << SH_365) + 364) / 365);
  localparam logic [9:0]  RCP_100   = 10'(((64'd1 << SH_100) + 99) / 100);
  localparam logic [11:0] RCP_153   = 12'(((64'd1 << SH_153) + 152) / 153);
  localparam logic [17:0] RCP_60S   = 18'(((64'd1 << SH_60S) + 59) / 60);
  localparam logic [11:0] RCP_60M   = 12'(((64'd1 << SH_60M) + 59) / 60);

  // One load enable per pipeline stage
  typedef logic [NSTG-1:0] stg_en_t;
  localparam stg_en_t STG_ONES = '1;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  // Day of the March-based year on which month index mp starts
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/ecal_split.sv
// Stages 0 to 2: range check and split of the seconds count into days and second of day.
// Depends on ecal_pkg.
module ecal_split (
  input  logic              clk,
  input  ecal_pkg::stg_en_t adv,
  input  logic [39:0]       ts,
  output logic [21:0]       days,
  output logic [16:0]       sod,
  output logic              oor
);
  import ecal_pkg::*;

  logic        oor0_r;
  logic [30:0] q0_r;
  logic [6:0]  lo0_r;
  logic [62:0] prod1_r;
  logic [30:0] q1_r;
  logic [6:0]  lo1_r;
  logic        oor1_r;
  logic [21:0] days2_r;
  logic [16:0] sod2_r;
  logic        oor2_r;

  logic [21:0] days_c;
  logic [31:0] dmul_c;
  logic [30:0] rem_c;

  // Stage 0: compare against the last second, drop the power-of-two part of a day
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      oor0_r <= (ts >= TS_LIMIT);
      q0_r   <= ts[37:DAY_LO_BITS];
      lo0_r  <= ts[DAY_LO_BITS-1:0];
    end
  end

  // Stage 1: multiply by the reciprocal of 675
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      prod1_r <= 63'(q0_r) * 63'(RCP_675);
      q1_r    <= q0_r;
      lo1_r   <= lo0_r;
      oor1_r  <= oor0_r;
    end
  end

  // Stage 2: take the day count and rebuild the second of day from the remainder
  always_comb begin
    days_c = prod1_r[62:SH_675];
    dmul_c = 32'(days_c) * 32'(DAY_ODD);
    rem_c  = q1_r - dmul_c[30:0];
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      days2_r <= days_c;
      sod2_r  <= {rem_c[9:0], lo1_r};
      oor2_r  <= oor1_r;
    end
  end

  assign days = days2_r;
  assign sod  = sod2_r;
  assign oor  = oor2_r;

endmodule

>>> src/ecal_tod.sv
// Stages 3 to 11: hour, minute and second from the second of day, delayed to meet the date.
// Depends on ecal_pkg.
module ecal_tod (
  input  logic              clk,
  input  ecal_pkg::stg_en_t adv,
  input  logic [16:0]       sod,
  output ecal_pkg::tod_t    tod
);
  import ecal_pkg::*;

  logic [34:0] pm3_r;
  logic [16:0] sod3_r;
  logic [10:0] mins4_r;
  logic [5:0]  sec4_r;
  logic [22:0] ph5_r;
  logic [10:0] mins5_r;
  logic [5:0]  sec5_r;
  tod_t        tod6_r;
  tod_t        dly_r [7:11];

  logic [10:0] mins_c;
  logic [16:0] mmul_c;
  logic [4:0]  hr_c;
  logic [10:0] hmul_c;

  // Stage 3: multiply by the reciprocal of 60
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      pm3_r  <= 35'(sod) * 35'(RCP_60S);
      sod3_r <= sod;
    end
  end

  // Stage 4: whole minutes of the day and the second within the minute
  always_comb begin
    mins_c = pm3_r[33:SH_60S];
    mmul_c = 17'(mins_c) * 17'(SECS_PER_MIN);
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      mins4_r <= mins_c;
      sec4_r  <= 6'(sod3_r - mmul_c);
    end
  end

  // Stage 5: multiply minutes by the reciprocal of 60
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      ph5_r   <= 23'(mins4_r) * 23'(RCP_60M);
      mins5_r <= mins4_r;
      sec5_r  <= sec4_r;
    end
  end

  // Stage 6: hour and minute within the hour
  always_comb begin
    hr_c   = ph5_r[21:SH_60M];
    hmul_c = 11'(hr_c) * 11'(SECS_PER_MIN);
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      tod6_r.hour   <= hr_c;
      tod6_r.minute <= 6'(mins5_r - hmul_c);
      tod6_r.second <= sec5_r;
    end
  end

  // Stages 7 to 11: hold the time of day in step with the date path
  always_ff @(posedge clk) begin
    if (adv[7]) begin
      dly_r[7] <= tod6_r;
    end
    for (int k = 8; k <= 11; k++) begin
      if (adv[k]) begin
        dly_r[k] <= dly_r[k-1];
      end
    end
  end

  assign tod = dly_r[11];

endmodule

>>> src/ecal_date.sv
// Stages 3 to 11: Gregorian year, month and day from the day count by 400-year eras.
// Depends on ecal_pkg.
module ecal_date (
  input  logic              clk,
  input  ecal_pkg::stg_en_t adv,
  input  logic [21:0]       days,
  output ecal_pkg::date_t   date
);
  import ecal_pkg::*;

  logic [21:0] z3_r;
  logic [44:0] ep3_r;
  logic [4:0]  era4_r;
  logic [17:0] doe4_r;
  logic [36:0] p1460_r;
  logic [36:0] p36524_r;
  logic        last5_r;
  logic [17:0] doe5_r;
  logic [4:0]  era5_r;
  logic [17:0] t6_r;
  logic [17:0] doe6_r;
  logic [4:0]  era6_r;
  logic [36:0] py7_r;
  logic [17:0] doe7_r;
  logic [4:0]  era7_r;
  logic [8:0]  yoe8_r;
  logic [2:0]  c100_8_r;
  logic [17:0] doe8_r;
  logic [4:0]  era8_r;
  logic [8:0]  doy9_r;
  logic [13:0] y9_r;
  logic [3:0]  mp10_r;
  logic [8:0]  doy10_r;
  logic [13:0] y10_r;
  date_t       date11_r;

  logic [21:0] z_c;
  logic [4:0]  era_c;
  logic [21:0] emul_c;
  logic [8:0]  yoe_c;
  logic [18:0] m100_c;
  logic [17:0] ydays_c;
  logic [10:0] v153_c;
  logic [22:0] pm_c;
  logic        jan_feb_c;

  // Stage 3: rebase to 0000-03-01 and multiply by the reciprocal of an era
  always_comb begin
    z_c = days + 22'(DAYS_TO_EPOCH);
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      z3_r  <= z_c;
      ep3_r <= 45'(z_c) * 45'(RCP_ERA);
    end
  end

  // Stage 4: era number and day of era
  always_comb begin
    era_c  = ep3_r[44:SH_ERA];
    emul_c = 22'(era_c) * 22'(DAYS_PER_ERA);
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      era4_r <= era_c;
      doe4_r <= 18'(z3_r - emul_c);
    end
  end

  // Stage 5: leap corrections within the era by reciprocal multiplies
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      p1460_r  <= 37'(doe4_r) * 37'(RCP_1460);
      p36524_r <= 37'(doe4_r) * 37'(RCP_36524);
      last5_r  <= (doe4_r == 18'(DAYS_PER_ERA - 1));
      doe5_r   <= doe4_r;
      era5_r   <= era4_r;
    end
  end

  // Stage 6: day of era with leap days folded out
  always_ff @(posedge clk) begin
    if (adv[6]) begin
      t6_r   <= doe5_r - 18'(p1460_r[36:SH_1460]) + 18'(p36524_r[36:SH_36524])
                - 18'(last5_r);
      doe6_r <= doe5_r;
      era6_r <= era5_r;
    end
  end

  // Stage 7: multiply by the reciprocal of 365
  always_ff @(posedge clk) begin
    if (adv[7]) begin
      py7_r  <= 37'(t6_r) * 37'(RCP_365);
      doe7_r <= doe6_r;
      era7_r <= era6_r;
    end
  end

  // Stage 8: year of era and its century count
  always_comb begin
    yoe_c  = py7_r[35:SH_365];
    m100_c = 19'(yoe_c) * 19'(RCP_100);
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      yoe8_r   <= yoe_c;
      c100_8_r <= m100_c[18:SH_100];
      doe8_r   <= doe7_r;
      era8_r   <= era7_r;
    end
  end

  // Stage 9: day of the March-based year and the year number
  always_comb begin
    ydays_c = 18'(yoe8_r) * 18'd365 + 18'(yoe8_r[8:2]) - 18'(c100_8_r);
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      doy9_r <= 9'(doe8_r - ydays_c);
      y9_r   <= 14'(era8_r) * 14'd400 + 14'(yoe8_r);
    end
  end

  // Stage 10: March-based month index
  always_comb begin
    v153_c = 11'(doy9_r) * 11'd5 + 11'd2;
    pm_c   = 23'(v153_c) * 23'(RCP_153);
  end

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      mp10_r  <= pm_c[22:SH_153];
      doy10_r <= doy9_r;
      y10_r   <= y9_r;
    end
  end

  // Stage 11: calendar month and day; January and February belong to the next year
  always_comb begin
    jan_feb_c = (mp10_r >= 4'd10);
  end

  always_ff @(posedge clk) begin
    if (adv[11]) begin
      date11_r.day   <= 5'(doy10_r - month_start(mp10_r) + 9'd1);
      date11_r.month <= jan_feb_c ? (mp10_r - 4'd9) : (mp10_r + 4'd3);
      date11_r.year  <= y10_r + 14'(jan_feb_c);
    end
  end

  assign date = date11_r;

endmodule

>>> src/epoch_seconds_to_calendar_unit.sv
// Top level of the epoch-seconds to calendar converter: stage control and output register.
// Depends on ecal_pkg, ecal_split, ecal_tod and ecal_date.
//
//  channel  | direction | handshake          | words
//  ---------+-----------+--------------------+---------------------------------------------
//  in_      | into      | in_valid/in_stall  | epoch_seconds
//  out_     | out of    | out_valid/out_stall| year month day hour minute second out_of_range
//
// Thirteen register stages, from stage 0 to the output register; when nothing stalls,
// one word enters and one leaves every cycle.
// The longest stage holds one reciprocal multiply of up to 31 x 32 bits.
// Reset empties every stage; no clearing sweep follows it.
// A stall on out_ holds the output register; earlier stages keep filling their empty slots
// and in_stall rises only once every stage holds a word.
module epoch_seconds_to_calendar_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [39:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic        out_out_of_range
);
  import ecal_pkg::*;

  stg_en_t     vld_r;
  stg_en_t     adv;
  logic [11:3] oor_r;
  logic [21:0] days;
  logic [16:0] sod;
  logic        oor;
  tod_t        tod;
  date_t       date;

  logic [13:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r;
  logic [5:0]  second_r;
  logic        oor_out_r;

  // Advance a stage when it is empty or every stage after it up to the output moves
  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      adv[k] = !out_stall || !(&(vld_r | (STG_ONES >> (NSTG - k))));
    end
  end

  // Carry valid bits along with the words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_stall = !adv[0];

  ecal_split u_split (
    .clk  (clk),
    .adv  (adv),
    .ts   (in_epoch_seconds),
    .days (days),
    .sod  (sod),
    .oor  (oor)
  );

  ecal_tod u_tod (
    .clk (clk),
    .adv (adv),
    .sod (sod),
    .tod (tod)
  );

  ecal_date u_date (
    .clk  (clk),
    .adv  (adv),
    .days (days),
    .date (date)
  );

  // Hold the range flag alongside the date and time paths
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      oor_r[3] <= oor;
    end
    for (int k = 4; k <= 11; k++) begin
      if (adv[k]) begin
        oor_r[k] <= oor_r[k-1];
      end
    end
  end

  // Output register: zero every field of an out-of-range word
  always_ff @(posedge clk) begin
    if (adv[NSTG-1]) begin
      oor_out_r <= oor_r[11];
      if (oor_r[11]) begin
        year_r   <= '0;
        month_r  <= '0;
        day_r    <= '0;
        hour_r   <= '0;
        minute_r <= '0;
        second_r <= '0;
      end else begin
        year_r   <= date.year;
        month_r  <= date.month;
        day_r    <= date.day;
        hour_r   <= tod.hour;
        minute_r <= tod.minute;
        second_r <= tod.second;
      end
    end
  end

  assign out_valid        = vld_r[NSTG-1];
  assign out_year         = year_r;
  assign out_month        = month_r;
  assign out_day          = day_r;
  assign out_hour         = hour_r;
  assign out_minute       = minute_r;
  assign out_second       = second_r;
  assign out_out_of_range = oor_out_r;

endmodule

>>> src/ecal_chk.sv
// Port-level checks for the epoch-seconds to calendar converter, bound to its top level.
// Depends on ecal_pkg and epoch_seconds_to_calendar_unit.
module ecal_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [39:0] in_epoch_seconds,
  input logic        out_valid,
  input logic        out_stall,
  input logic [13:0] out_year,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day,
  input logic [4:0]  out_hour,
  input logic [5:0]  out_minute,
  input logic [5:0]  out_second,
  input logic        out_out_of_range
);
  import ecal_pkg::*;

  // An out-of-range word carries no date or time
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |->
      out_year == 14'd0 && out_month == 4'd0 && out_day == 5'd0 &&
      out_hour == 5'd0 && out_minute == 6'd0 && out_second == 6'd0)
    else $error("out-of-range word with non-zero fields");

  // A converted date lies in the supported calendar
  a_date_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |->
      out_year >= 14'd1970 && out_year <= 14'(MAX_YEAR) &&
      out_month >= 4'd1 && out_month <= 4'd12 &&
      out_day >= 5'd1 && out_day <= 5'd31)
    else $error("date outside the calendar");

  // A converted time of day is well formed
  a_tod_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |->
      out_hour <= 5'd23 && out_minute <= 6'd59 && out_second <= 6'd59)
    else $error("time of day out of range");

  // A stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_year) && $stable(out_month) && $stable(out_day) &&
      $stable(out_hour) && $stable(out_minute) && $stable(out_second) &&
      $stable(out_out_of_range))
    else $error("stalled result word changed");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind epoch_seconds_to_calendar_unit ecal_chk u_ecal_chk (.*);
